/* rtl/core/pli_pkg.sv */
// Shared types and constants for the positional list block.
`timescale 1ns / 1ps

package pli_pkg;

	localparam int DUMP_MAX = 16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_DUMP   = 2'd2,
		OP_BAD    = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_RANGE   = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_SH_RD,
		S_SH_WR,
		S_PUT,
		S_DUMP_RD,
		S_DUMP_OUT,
		S_RESP
	} state_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] element;
		logic        has_element;
		logic [4:0]  list_length;
		logic        last;
	} res_t;

endpackage

/* rtl/core/positional_list_insert_delete.sv */
// Top level of the positional list: store, sequencer and output register.
//
//  channel | dir | tdata (low bit up)                     | tuser         | tlast
//  s_*     | in  | item_value[31:0], position[39:32]      | opcode[1:0]   | -
//  m_*     | out | status[2:0], element[34:3], len[39:35] | has_element   | last of item
//
// Each item is captured in S_IDLE and decided in S_EVAL. Insert and delete
// move one element at a time through the single store port pair (read,
// then write), and insert then writes the new value; a rejected item goes
// straight to its response. A dump emits its elements one at a time, each
// from a registered read, and reads the next only once the last is taken.
// Reset clears the element count and the control state; the store needs no
// clearing since only occupied entries are ever read. An output stall holds
// the sequencer on its pending result; input is taken only between items.
`timescale 1ns / 1ps

module positional_list_insert_delete import pli_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // item_value[31:0], position[39:32]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // status[2:0], element[34:3], list_length[39:35]
	output logic        m_tuser,   // has_element
	output logic        m_tlast
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = (CNT_W + 1 > 9) ? CNT_W + 1 : 9;

	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	logic [31:0]      mem_wdata, mem_rdata;
	logic             res_valid, res_ready;
	res_t             res;
	logic             out_valid_q;
	res_t             out_q;

	pli_store #(.DEPTH(CAPACITY), .IDX_W(IDX_W)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pli_ctrl #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (opcode_t'(s_tuser)),
		.value     (s_tdata[31:0]),
		.pos       (s_tdata[39:32]),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	// the slot frees up when empty or when its item is taken this cycle
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result payload until it is replaced
	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.list_length, out_q.element, out_q.status};
	assign m_tuser  = out_q.has_element;
	assign m_tlast  = out_q.last;

	// a result without a value always reads zero in the element field
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[34:3] == 32'd0)
		else $error("element not zero without has_element");

	// only dumped elements may be followed by more results of the same item
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser)
		else $error("non-final result without element");

	// an error status ends the item
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != ST_OK |-> m_tlast && !m_tuser)
		else $error("error status on a non-final result");

	// the block is busy right after taking an item
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after accept");

endmodule

/* rtl/core/pli_step.sv */
// Shared index step unit: increment or decrement plus one magnitude compare.
`timescale 1ns / 1ps

module pli_step #(
	parameter int CW = 9
) (
	input  logic [CW-1:0] idx,
	input  logic          dec,
	input  logic          cmp_step,
	input  logic [CW-1:0] bound,
	output logic [CW-1:0] step,
	output logic          lt
);

	logic [CW-1:0] cmp_a;

	assign step  = dec ? (idx - CW'(1)) : (idx + CW'(1));
	assign cmp_a = cmp_step ? step : idx;
	assign lt    = (cmp_a < bound);

endmodule

/* rtl/core/pli_store.sv */
// Element storage: one write port, one read port with registered data.
`timescale 1ns / 1ps

module pli_store #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [31:0]      wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output logic [31:0]      rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/pli_ctrl.sv */
// Sequencer for insert, delete and dump, driving the store and the step unit.
`timescale 1ns / 1ps

module pli_ctrl import pli_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int IDX_W    = 4,
	parameter int CNT_W    = 5,
	parameter int CW       = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  opcode_t          op,
	input  logic [31:0]      value,
	input  logic [7:0]       pos,
	output logic             mem_we,
	output logic [IDX_W-1:0] mem_waddr,
	output logic [31:0]      mem_wdata,
	output logic             mem_re,
	output logic [IDX_W-1:0] mem_raddr,
	input  logic [31:0]      mem_rdata,
	input  logic             res_ready,
	output logic             res_valid,
	output res_t             res
);

	state_t         state_q, state_d;
	opcode_t        op_q;
	logic [31:0]    val_q;
	logic [7:0]     pos_q;
	logic [CNT_W-1:0] occ_q;
	logic [CW-1:0]  idx_q;
	logic [CW-1:0]  bound_q;
	status_t        status_q;

	logic [CW-1:0]  pos_w, occ_w, step;
	logic           lt, ins, more, last_dump;
	state_t         ev_next;
	status_t        ev_status;
	logic [CW-1:0]  ev_bound, ev_idx;
	logic [4:0]     len;

	assign pos_w = CW'(pos_q);
	assign occ_w = CW'(occ_q);
	assign ins   = (op_q == OP_INSERT);
	assign len   = occ_w[4:0];

	pli_step #(.CW(CW)) u_step (
		.idx      (idx_q),
		.dec      (ins),
		.cmp_step (!ins),
		.bound    (bound_q),
		.step     (step),
		.lt       (lt)
	);

	// insert: keep shifting while idx >= pos; delete: while idx+1 < occupancy
	assign more      = ins ? !lt : lt;
	assign last_dump = !lt;

	// decide the operation from the captured item
	always_comb begin
		ev_next   = S_RESP;
		ev_status = ST_OK;
		ev_bound  = '0;
		ev_idx    = '0;
		unique case (op_q)
			OP_INSERT: begin
				priority if (pos_w == '0) begin
					ev_status = ST_INVALID;
				end else if (occ_w >= CW'(CAPACITY)) begin
					ev_status = ST_FULL;
				end else if (occ_w == '0) begin
					ev_next  = S_SH_RD;
					ev_bound = CW'(1);
				end else if (pos_w > occ_w + CW'(1)) begin
					ev_status = ST_RANGE;
				end else begin
					ev_next  = S_SH_RD;
					ev_bound = pos_w;
					ev_idx   = occ_w;
				end
			end
			OP_DELETE: begin
				priority if (occ_w == '0) begin
					ev_status = ST_EMPTY;
				end else if (pos_w == '0) begin
					ev_status = ST_INVALID;
				end else if (pos_w > occ_w) begin
					ev_status = ST_RANGE;
				end else begin
					ev_next  = S_SH_RD;
					ev_bound = occ_w;
					ev_idx   = pos_w - CW'(1);
				end
			end
			OP_DUMP: begin
				if (occ_w != '0) begin
					ev_next  = S_DUMP_RD;
					ev_bound = (occ_w > CW'(DUMP_MAX)) ? CW'(DUMP_MAX) : occ_w;
				end
			end
			default: begin
				ev_status = ST_INVALID;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (in_valid) state_d = S_EVAL;
			S_EVAL:     state_d = ev_next;
			S_SH_RD:    state_d = more ? S_SH_WR : (ins ? S_PUT : S_RESP);
			S_SH_WR:    state_d = S_SH_RD;
			S_PUT:      state_d = S_RESP;
			S_DUMP_RD:  state_d = S_DUMP_OUT;
			S_DUMP_OUT: if (res_ready) state_d = last_dump ? S_IDLE : S_DUMP_RD;
			S_RESP:     if (res_ready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = step[IDX_W-1:0];
		res_valid = 1'b0;
		res       = '{status: status_q, element: '0, has_element: 1'b0,
		              list_length: len, last: 1'b1};
		unique case (state_q)
			S_IDLE:  in_ready = 1'b1;
			S_SH_RD: mem_re = more;
			S_SH_WR: mem_we = 1'b1;
			S_PUT: begin
				mem_we    = 1'b1;
				mem_wdata = val_q;
			end
			S_DUMP_RD: begin
				mem_re    = 1'b1;
				mem_raddr = idx_q[IDX_W-1:0];
			end
			S_DUMP_OUT: begin
				res_valid = res_ready;
				res       = '{status: ST_OK, element: mem_rdata, has_element: 1'b1,
				              list_length: len, last: last_dump};
			end
			S_RESP:  res_valid = res_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_PUT) begin
				occ_q <= occ_q + CNT_W'(1);
			end else if (state_q == S_SH_RD && !more && !ins) begin
				occ_q <= occ_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q  <= op;
					val_q <= value;
					pos_q <= pos;
				end
			end
			S_EVAL: begin
				status_q <= ev_status;
				bound_q  <= ev_bound;
				idx_q    <= ev_idx;
			end
			S_SH_WR: idx_q <= step;
			S_DUMP_OUT: begin
				if (res_ready) idx_q <= step;
			end
			default: ;
		endcase
	end

endmodule

/* test/pli_list_checker.sv */
// Checker for the positional list: mirrors the list, predicts every result and compares.
`timescale 1ns / 1ps

module pli_list_checker import pli_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // item_value[31:0], position[39:32]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // status[2:0], element[34:3], list_length[39:35]
	input  logic        m_tuser,   // has_element
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending,
	output int          list_len
);

	logic [31:0] cells [CAPACITY];
	int unsigned n_cells;
	res_t        awaited_results [$];
	int          errors;

	function automatic status_t insert_cell(logic [31:0] val, int unsigned pos);
		int unsigned i;
		if (pos == 0)
			return ST_INVALID;
		if (n_cells >= CAPACITY)
			return ST_FULL;
		if (n_cells == 0) begin
			cells[0] = val;
			n_cells = 1;
			return ST_OK;
		end
		if (pos > n_cells + 1)
			return ST_RANGE;
		for (i = n_cells; i > pos - 1; i--)
			cells[i] = cells[i - 1];
		cells[pos - 1] = val;
		n_cells++;
		return ST_OK;
	endfunction

	function automatic status_t delete_cell(int unsigned pos);
		int unsigned i;
		if (n_cells == 0)
			return ST_EMPTY;
		if (pos == 0)
			return ST_INVALID;
		if (pos > n_cells)
			return ST_RANGE;
		for (i = pos - 1; i + 1 < n_cells; i++)
			cells[i] = cells[i + 1];
		n_cells--;
		return ST_OK;
	endfunction

	// Apply one accepted item to the mirror and queue the results it causes.
	function automatic void apply_list_op(opcode_t op, logic [31:0] val, logic [7:0] pos);
		res_t        r;
		int unsigned n;
		r = '0;
		r.last = 1'b1;
		case (op)
			OP_INSERT: r.status = insert_cell(val, 32'(pos));
			OP_DELETE: r.status = delete_cell(32'(pos));
			OP_DUMP: begin
				r.status = ST_OK;
				n = (n_cells > DUMP_MAX) ? DUMP_MAX : n_cells;
				for (int unsigned k = 0; k < n; k++) begin
					r.element     = cells[k];
					r.has_element = 1'b1;
					r.list_length = n_cells[4:0];
					r.last        = (k + 1 == n);
					awaited_results.push_back(r);
				end
				if (n != 0)
					return;
			end
			default: r.status = ST_INVALID;
		endcase
		r.list_length = n_cells[4:0];
		awaited_results.push_back(r);
	endfunction

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
				exp_val, act_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t exp_res;
		if (!arst_n) begin
			n_cells = 0;
			errors  = 0;
			awaited_results.delete();
		end else begin
			// take the input first so a same-edge result still finds its expectation
			if (s_tvalid && s_tready)
				apply_list_op(opcode_t'(s_tuser), s_tdata[31:0], s_tdata[39:32]);
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %h/%b/%b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					exp_res = awaited_results.pop_front();
					check_field("status", 32'(exp_res.status), 32'(m_tdata[2:0]));
					check_field("element", exp_res.element, m_tdata[34:3]);
					check_field("list_length", 32'(exp_res.list_length),
						32'(m_tdata[39:35]));
					check_field("has_element", 32'(exp_res.has_element), 32'(m_tuser));
					check_field("last", 32'(exp_res.last), 32'(m_tlast));
				end
			end
		end
		fail_count <= errors;
		pending    <= awaited_results.size();
		list_len   <= n_cells;
	end

endmodule

/* test/positional_list_insert_delete_tb.sv */
// Testbench top for the positional list: stimulus, idling, timeout and verdict.
`timescale 1ns / 1ps

module positional_list_insert_delete_tb import pli_pkg::*;;

	localparam int CAPACITY    = 16;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 26;
	// worst case is far below this, even for a full dump under maximum stall
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN       = 80;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // item_value[31:0], position[39:32]
	logic [1:0]  s_tuser;   // opcode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;   // status[2:0], element[34:3], list_length[39:35]
	logic        m_tuser;   // has_element
	logic        m_tlast;

	int fail_count;
	int pending;
	int list_len;
	int cycle_cnt = 0;
	int stall_cnt = 0;
	bit gaps_on   = 1'b0;
	bit stalls_on = 1'b0;

	always #4 clk = ~clk;

	positional_list_insert_delete #(.CAPACITY(CAPACITY)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	pli_list_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending),
		.list_len   (list_len)
	);

	// Stall the result side in random bursts while stalls are enabled.
	// A burst sets tready low now and raises it again when its random down-counter runs out.
	always @(posedge clk) begin
		if (stall_cnt != 0) begin
			stall_cnt <= stall_cnt - 1;
			m_tready  <= (stall_cnt == 1);
		end else if (stalls_on && $urandom_range(0, 6) == 0) begin
			stall_cnt <= $urandom_range(1, 6);
			m_tready  <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Abort on a hung handshake.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Present one item and hold it until the block takes it. Valid stays high
	// after acceptance so the next call can follow back to back; a gap lowers it
	// in its own time step, so valid never sees two assignments in one step.
	task automatic send_item(input opcode_t op, input logic [31:0] val, input logic [7:0] pos);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pos, val};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Word extremes and sign patterns now and then, random otherwise.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 11))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// One random item. grow_pct biases insert over delete so the list swings
	// between empty and full; positions are mostly in range, sometimes zero,
	// anywhere in the byte, or the top code. list_len may trail by one item,
	// which only nudges the mix toward out-of-range cases.
	task automatic random_item(input int grow_pct);
		int          r;
		int          len;
		opcode_t     op;
		logic [7:0]  pos;
		len = list_len;
		r   = $urandom_range(0, 99);
		if (r < 4)
			op = OP_BAD;
		else if (r < 14)
			op = OP_DUMP;
		else if (r < 14 + (grow_pct * 86) / 100)
			op = OP_INSERT;
		else
			op = OP_DELETE;
		r = $urandom_range(0, 99);
		if (r < 6)
			pos = 8'd0;
		else if (r < 13)
			pos = 8'($urandom_range(0, 255));
		else if (r < 16)
			pos = 8'd255;
		else if (op == OP_INSERT)
			pos = 8'($urandom_range(1, len + 1));
		else
			pos = (len == 0) ? 8'd1 : 8'($urandom_range(1, len));
		send_item(op, pick_value(), pos);
	endtask

	initial begin
		int k;
		// known values on every input from time zero
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_INSERT;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-list cases first
		send_item(OP_DUMP, 32'h1234_5678, 8'd1);     // dump of empty list: one bare result
		send_item(OP_DELETE, 32'h0, 8'd0);           // empty check precedes position check
		send_item(OP_INSERT, 32'h5555_5555, 8'd0);   // position zero rejected
		send_item(OP_INSERT, 32'h7FFF_FFFF, 8'd255); // any nonzero position inserts into empty list
		send_item(OP_INSERT, 32'h8000_0000, 8'd1);   // insert at head
		send_item(OP_INSERT, 32'hFFFF_FFFF, 8'd3);   // append at length+1
		send_item(OP_INSERT, 32'h0, 8'd5);           // beyond length+1
		send_item(OP_BAD, 32'hAAAA_AAAA, 8'd2);      // unknown opcode
		send_item(OP_DELETE, 32'h0, 8'd0);           // delete at position zero
		send_item(OP_DELETE, 32'h0, 8'd4);           // delete beyond length
		send_item(OP_DUMP, 32'h0, 8'd0);
		send_item(OP_DELETE, 32'h0, 8'd2);           // middle element
		send_item(OP_DELETE, 32'h0, 8'd2);           // tail element
		// fill to capacity at random positions, then hit the full cases
		for (k = 1; k < CAPACITY; k++)
			send_item(OP_INSERT, pick_value(), 8'($urandom_range(1, k + 1)));
		send_item(OP_INSERT, 32'h0000_0001, 8'd3);   // list full
		send_item(OP_INSERT, 32'h0000_0001, 8'd0);   // zero position wins over full
		send_item(OP_DUMP, 32'h0, 8'd0);             // longest dump
		send_item(OP_DELETE, 32'h0, 8'd255);

		// Random: alternate growing and shrinking phases with random idling,
		// and leave the final phase free of gaps and stalls.
		for (int p = 0; p < PHASES; p++) begin
			gaps_on   = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
			stalls_on = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
			for (int i = 0; i < PHASE_ITEMS; i++)
				random_item((p % 2 == 0) ? 75 : 25);
		end
		s_tvalid <= 1'b0;

		// let the last acceptance land in the checker, then drain all results
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
